// ===== rtl/core/s2dconv_pkg.sv =====
// shared constants, types and codes of the streaming 2d convolution core
package s2dconv_pkg;

   localparam int KERNEL_ROWS = 17;
   localparam int KERNEL_COLS = 17;
   localparam int LINE_MAX    = 1024;
   localparam int PIXEL_WIDTH = 8;
   localparam int ACC_WIDTH   = 32;

   localparam int HALF_R      = KERNEL_ROWS / 2;
   localparam int HALF_C      = KERNEL_COLS / 2;
   localparam int KSIZE       = KERNEL_ROWS * KERNEL_COLS;
   localparam int LINE_ROWS   = KERNEL_ROWS - 1;
   localparam int LINE_WORD_W = LINE_ROWS * PIXEL_WIDTH;
   localparam int ADDR_W      = $clog2(LINE_MAX);
   localparam int KIDX_W      = $clog2(KSIZE);
   localparam int MAC_CNT_W   = $clog2(KSIZE + 3);
   localparam int CLEAR_COUNT = (LINE_MAX > KSIZE) ? LINE_MAX : KSIZE;
   localparam int CLR_W       = $clog2(CLEAR_COUNT);
   localparam int DIV_CNT_W   = $clog2(ACC_WIDTH + 1);

   // fixed field widths
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int DIVISOR_W   = 15;
   localparam int OFFSET_W    = 16;
   localparam int COEF_W      = 16;
   localparam int COEF_IDX_W  = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int HEIGHT_MAX  = 4096;
   localparam int PROD_W      = PIXEL_WIDTH + 1 + COEF_W;

   // item commands
   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_COEF = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_MAC,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic coef_wr;
      logic line_rd;
      logic line_upd;
      logic mac_start;
      logic mac_step;
      logic div_start;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic emit_needed;
      logic mac_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/s2dconv_ctrl.sv =====
// sequencing state machine of the convolution core
module s2dconv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   input  s2dconv_pkg::status_type status,
   output s2dconv_pkg::cmd_type    cmd,
   output logic                   req_stall
);
   import s2dconv_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_cmd == CMD_STEP) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.emit_needed ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            if (status.mac_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.accept  = req_valid;
            cmd.coef_wr = req_valid && req_cmd == CMD_COEF;
            cmd.line_rd = req_valid && req_cmd == CMD_STEP;
         end
         ST_UPDATE: begin
            cmd.line_upd  = 1'b1;
            cmd.mac_start = status.emit_needed;
         end
         ST_MAC: begin
            cmd.mac_step  = 1'b1;
            cmd.div_start = status.mac_done;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/s2dconv_dp.sv =====
// line store, window, coefficient table, mac, divider and output register
module s2dconv_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  s2dconv_pkg::cmd_type                   cmd,
   output s2dconv_pkg::status_type                status,
   input  logic [s2dconv_pkg::PIXEL_WIDTH-1:0]    req_pixel_in,
   input  logic [s2dconv_pkg::COEF_IDX_W-1:0]     req_coef_index,
   input  logic signed [s2dconv_pkg::COEF_W-1:0]  req_coef_value,
   input  logic                                   csr_wr_en,
   input  logic [s2dconv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [s2dconv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [s2dconv_pkg::PIXEL_WIDTH-1:0]    rsp_pixel_out,
   output logic                                   rsp_frame_last
);
   import s2dconv_pkg::*;

   // configuration
   logic [WIDTH_W-1:0]   width_ff;
   logic [HEIGHT_W-1:0]  height_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [OFFSET_W-1:0]  offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_W'(LINE_MAX);
         height_ff  <= HEIGHT_W'(480);
         divisor_ff <= DIVISOR_W'(1);
         offset_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_WIDTH:   width_ff   <= csr_wdata[WIDTH_W-1:0];
            REG_HEIGHT:  height_ff  <= csr_wdata[HEIGHT_W-1:0];
            REG_DIVISOR: divisor_ff <= csr_wdata[DIVISOR_W-1:0];
            REG_OFFSET:  offset_ff  <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WIDTH_W-1:0]   w_eff;
   logic [HEIGHT_W-1:0]  h_eff;
   logic [DIVISOR_W-1:0] d_eff;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = WIDTH_W'(1);
      if (int'(width_ff) > LINE_MAX) w_eff = WIDTH_W'(LINE_MAX);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = HEIGHT_W'(1);
      if (int'(height_ff) > HEIGHT_MAX) h_eff = HEIGHT_W'(HEIGHT_MAX);
      d_eff = (divisor_ff == '0) ? DIVISOR_W'(1) : divisor_ff;
   end

   // clearing pass over line store and coefficient table
   logic [CLR_W-1:0] clear_cnt_ff;
   logic             clear_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff  <= '0;
         clear_done_ff <= 1'b0;
      end else if (cmd.clear_step && !clear_done_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (int'(clear_cnt_ff) == CLEAR_COUNT - 1) clear_done_ff <= 1'b1;
      end
   end

   // scan counters
   logic [HEIGHT_W-1:0]    row_ff;
   logic [WIDTH_W-1:0]     col_ff;
   logic [PIXEL_WIDTH-1:0] pix_ff;
   logic                   in_col, in_row, row_end, frame_end;

   assign in_col    = col_ff < w_eff;
   assign in_row    = row_ff < h_eff;
   assign row_end   = ({1'b0, col_ff} + 1'b1) >= ({1'b0, w_eff} + (WIDTH_W+1)'(HALF_C));
   assign frame_end = row_end &&
                      (({1'b0, row_ff} + 1'b1) >= ({1'b0, h_eff} + (HEIGHT_W+1)'(HALF_R)));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.line_upd) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= frame_end ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) pix_ff <= req_pixel_in;
   end

   // line store: one word holds a column of all stored rows
   logic [LINE_WORD_W-1:0] line_mem [LINE_MAX];
   logic [LINE_WORD_W-1:0] line_rd_ff;
   logic [LINE_WORD_W-1:0] line_new;

   always_comb begin
      for (int r = 0; r < LINE_ROWS - 1; r++) begin
         line_new[r*PIXEL_WIDTH +: PIXEL_WIDTH] = line_rd_ff[(r+1)*PIXEL_WIDTH +: PIXEL_WIDTH];
      end
      line_new[(LINE_ROWS-1)*PIXEL_WIDTH +: PIXEL_WIDTH] =
         in_row ? pix_ff : line_rd_ff[(LINE_ROWS-1)*PIXEL_WIDTH +: PIXEL_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step && !clear_done_ff && int'(clear_cnt_ff) < LINE_MAX) begin
         line_mem[clear_cnt_ff[ADDR_W-1:0]] <= '0;
      end else if (cmd.line_upd && in_col) begin
         line_mem[col_ff[ADDR_W-1:0]] <= line_new;
      end
      if (cmd.line_rd) line_rd_ff <= line_mem[col_ff[ADDR_W-1:0]];
   end

   // coefficient table
   logic signed [COEF_W-1:0] coef_mem [KSIZE];
   logic signed [COEF_W-1:0] coef_rd_ff;
   logic [MAC_CNT_W-1:0]     mac_cnt_ff;
   logic                     mac_issue;

   assign mac_issue = cmd.mac_step && int'(mac_cnt_ff) < KSIZE;

   always_ff @(posedge clock) begin
      if (cmd.clear_step && !clear_done_ff && int'(clear_cnt_ff) < KSIZE) begin
         coef_mem[clear_cnt_ff[KIDX_W-1:0]] <= '0;
      end else if (cmd.coef_wr && int'(req_coef_index) < KSIZE) begin
         coef_mem[req_coef_index[KIDX_W-1:0]] <= req_coef_value;
      end
      if (mac_issue) coef_rd_ff <= coef_mem[mac_cnt_ff[KIDX_W-1:0]];
   end

   // pixel window, row-major, rotated by one entry per mac step
   logic [PIXEL_WIDTH-1:0] win_ff [KSIZE];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KSIZE; i++) win_ff[i] <= '0;
      end else if (cmd.line_upd) begin
         for (int r = 0; r < KERNEL_ROWS; r++) begin
            for (int c = 0; c < KERNEL_COLS - 1; c++) begin
               win_ff[r*KERNEL_COLS + c] <= win_ff[r*KERNEL_COLS + c + 1];
            end
         end
         if (in_col) begin
            for (int r = 0; r < LINE_ROWS; r++) begin
               win_ff[r*KERNEL_COLS + KERNEL_COLS - 1] <= line_rd_ff[r*PIXEL_WIDTH +: PIXEL_WIDTH];
            end
            if (in_row) win_ff[KSIZE-1] <= pix_ff;
         end
      end else if (mac_issue) begin
         for (int i = 0; i < KSIZE - 1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[KSIZE-1] <= win_ff[0];
      end
   end

   // mac pipeline: fetch, multiply, accumulate
   logic [PIXEL_WIDTH-1:0]   mac_pix_ff;
   logic                     v1_ff, v2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_WIDTH-1:0]     acc_ff;

   always_ff @(posedge clock) begin
      if (mac_issue) mac_pix_ff <= win_ff[0];
      prod_ff <= $signed({1'b0, mac_pix_ff}) * coef_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_cnt_ff <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         acc_ff     <= '0;
      end else if (cmd.mac_start) begin
         mac_cnt_ff <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         acc_ff     <= '0;
      end else if (cmd.mac_step) begin
         if (int'(mac_cnt_ff) < KSIZE + 2) mac_cnt_ff <= mac_cnt_ff + 1'b1;
         v1_ff <= mac_issue;
         v2_ff <= v1_ff;
         if (v2_ff) acc_ff <= acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   // restoring divider on magnitudes, one quotient bit per cycle
   logic                   neg_ff;
   logic [ACC_WIDTH-1:0]   quo_ff;
   logic [DIVISOR_W:0]     rem_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [DIVISOR_W+1:0]   rem_shift;
   logic [DIVISOR_W+1:0]   rem_sub;

   assign rem_shift = {rem_ff, quo_ff[ACC_WIDTH-1]};
   assign rem_sub   = rem_shift - {2'b00, d_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step && int'(div_cnt_ff) < ACC_WIDTH) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= acc_ff[ACC_WIDTH-1];
         quo_ff <= acc_ff[ACC_WIDTH-1] ? (~acc_ff + 1'b1) : acc_ff;
         rem_ff <= '0;
      end else if (cmd.div_step && int'(div_cnt_ff) < ACC_WIDTH) begin
         if (rem_shift >= {2'b00, d_eff}) begin
            rem_ff <= rem_sub[DIVISOR_W:0];
            quo_ff <= {quo_ff[ACC_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[DIVISOR_W:0];
            quo_ff <= {quo_ff[ACC_WIDTH-2:0], 1'b0};
         end
      end
   end

   // result latch of the step flags, taken when the step updates
   logic frame_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.line_upd) frame_last_ff <= frame_end;
   end

   // output register
   logic                   rsp_valid_ff;
   logic [PIXEL_WIDTH-1:0] rsp_pixel_ff;
   logic                   rsp_last_ff;
   logic [PIXEL_WIDTH-1:0] q_low;

   assign q_low = neg_ff ? (~quo_ff[PIXEL_WIDTH-1:0] + 1'b1) : quo_ff[PIXEL_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pixel_ff <= q_low + offset_ff[PIXEL_WIDTH-1:0];
         rsp_last_ff  <= frame_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

   assign status.clear_done  = clear_done_ff;
   assign status.emit_needed = int'(row_ff) >= HALF_R && int'(col_ff) >= HALF_C;
   assign status.mac_done    = int'(mac_cnt_ff) == KSIZE + 2;
   assign status.div_done    = int'(div_cnt_ff) == ACC_WIDTH;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== rtl/core/streaming_2d_convolution_core.sv =====
// streaming 2d convolution core: raster scan with line store and sliding window
// sequence: a coefficient write is taken in the idle state; a scan step passes the idle and
//   update states, and when it yields a pixel also the mac loop (one multiplier), divider and emit
// throughput: one step item at a time; the mac loop, the divider and a stalled output set the rate
// reset: synchronous; a clearing pass zeroes line store and kernel table
//   before the first item is taken, configuration writes are taken throughout
module streaming_2d_convolution_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [s2dconv_pkg::PIXEL_WIDTH-1:0]    req_pixel_in,
   input  logic [s2dconv_pkg::COEF_IDX_W-1:0]     req_coef_index,
   input  logic signed [s2dconv_pkg::COEF_W-1:0]  req_coef_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [s2dconv_pkg::PIXEL_WIDTH-1:0]    rsp_pixel_out,
   output logic                                   rsp_frame_last,
   // register write port
   input  logic                                   csr_wr_en,
   input  logic [s2dconv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [s2dconv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import s2dconv_pkg::*;

   // commands down, status up
   cmd_type    cmd;
   status_type status;

   // sequencer: clear, accept, update, mac, divide, emit
   s2dconv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // storage and arithmetic
   s2dconv_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_pixel_in   (req_pixel_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
